// ===== hdl/hcb_pkg.sv =====
package hcb_pkg;

   // Default build limits
   localparam int MAX_SYMBOLS_DEF = 16;
   localparam int WEIGHT_BITS_DEF = 16;

   // Stream payload layout
   localparam int REQ_WEIGHT_W  = 16;
   localparam int REQ_TDATA_W   = 16;
   localparam int RSP_SYMBOL_W  = 4;
   localparam int RSP_CODE_W    = 15;
   localparam int RSP_LENGTH_W  = 4;
   localparam int RSP_TDATA_W   = 24;
   localparam int RSP_PAD_W     = RSP_TDATA_W - RSP_SYMBOL_W - RSP_CODE_W - RSP_LENGTH_W;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_CLEAR  = 9'b000000010,
      S_SCAN   = 9'b000000100,
      S_DRAIN  = 9'b000001000,
      S_WR1    = 9'b000010000,
      S_WR2    = 9'b000100000,
      S_WSTART = 9'b001000000,
      S_WPAR   = 9'b010000000,
      S_OUT    = 9'b100000000
   } state_type;

endpackage

// ===== hdl/hcb_ram.sv =====
module hcb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/huffman_code_builder_top.sv =====
// Huffman code builder. Symbol weights stream in one per transaction; the transaction
// with tlast set closes the set. The block then drops req_tready, clears the 2n-1 parent
// links, and runs n-1 merges, each a linear scan over the nodes built so far through one
// shared two-minimum compare unit plus two write states; merge i builds node i, for
// n <= i < 2n-1. Codes come out in symbol order, one per transaction; each walks leaf to
// root at one level per cycle. Weights past MAX_SYMBOLS are dropped and every code of
// that set shows the overflow flag.
module huffman_code_builder_top #(
   parameter int MAX_SYMBOLS = hcb_pkg::MAX_SYMBOLS_DEF,
   parameter int WEIGHT_BITS = hcb_pkg::WEIGHT_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [hcb_pkg::REQ_TDATA_W-1:0] req_tdata,  // [15:0] weight
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [3:0] symbol_index, [18:4] code_bits, [22:19] code_length, [23] zero
   output logic [hcb_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                            rsp_tuser,  // [0] overflow
   output logic                            rsp_tlast
);

   localparam int NODE_COUNT = 2 * MAX_SYMBOLS - 1;
   localparam int NI = $clog2(NODE_COUNT);
   localparam int CW = $clog2(MAX_SYMBOLS + 1);
   localparam int DW = $clog2(MAX_SYMBOLS);
   localparam int NW = WEIGHT_BITS + $clog2(MAX_SYMBOLS);
   localparam int CODE_W = hcb_pkg::RSP_CODE_W;

   hcb_pkg::state_type state_ff, state_in;

   logic [CW-1:0]     count_ff, count_in;
   logic              dropped_ff, dropped_in;
   logic [CW-1:0]     n_ff, n_in;
   logic [NI-1:0]     total_ff, total_in;
   logic [NI-1:0]     i_ff, i_in;
   logic [NI-1:0]     j_ff, j_in;
   logic              scan_vld_ff, scan_vld_in;
   logic [NI-1:0]     scan_idx_ff, scan_idx_in;
   logic              best_vld_ff, best_vld_in;
   logic [NI-1:0]     best_idx_ff, best_idx_in;
   logic [NW-1:0]     best_w_ff, best_w_in;
   logic              sec_vld_ff, sec_vld_in;
   logic [NI-1:0]     sec_idx_ff, sec_idx_in;
   logic [NW-1:0]     sec_w_ff, sec_w_in;
   logic [CW-1:0]     s_ff, s_in;
   logic [NI-1:0]     node_ff, node_in;
   logic [NI-1:0]     child_ff, child_in;
   logic              have_left_ff, have_left_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic [DW-1:0]     depth_ff, depth_in;

   // RAM ports
   logic          wt_we, par_we, lft_we;
   logic [NI-1:0] wt_waddr, par_waddr, lft_waddr;
   logic [NW-1:0] wt_wdata, wt_rdata;
   logic [NI-1:0] par_wdata, par_rdata, lft_wdata, lft_rdata;
   logic [NI-1:0] wt_raddr, par_raddr, lft_raddr;

   logic [31:0]       w_ext;
   logic [NW-1:0]     w_used;
   logic [CODE_W-1:0] code_nx;
   logic [DW-1:0]     depth_nx;
   logic [NI-1:0]     up_idx;
   logic [31:0]       sym_ext, depth_ext;

   assign w_ext  = 32'(req_tdata);
   assign w_used = NW'(w_ext[WEIGHT_BITS-1:0]);
   assign up_idx = par_rdata - NI'(1);

   hcb_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_weight_ram (
      .clock   (clock),
      .wr_en   (wt_we),
      .wr_addr (wt_waddr),
      .wr_data (wt_wdata),
      .rd_addr (wt_raddr),
      .rd_data (wt_rdata)
   );

   // parent link holds parent index plus one, zero for a root
   hcb_ram #(.WIDTH(NI), .DEPTH(NODE_COUNT)) u_parent_ram (
      .clock   (clock),
      .wr_en   (par_we),
      .wr_addr (par_waddr),
      .wr_data (par_wdata),
      .rd_addr (par_raddr),
      .rd_data (par_rdata)
   );

   hcb_ram #(.WIDTH(NI), .DEPTH(NODE_COUNT)) u_left_ram (
      .clock   (clock),
      .wr_en   (lft_we),
      .wr_addr (lft_waddr),
      .wr_data (lft_wdata),
      .rd_addr (lft_raddr),
      .rd_data (lft_rdata)
   );

   // one level of the code walk: left data belongs to node_ff, reached from child_ff
   always_comb begin
      code_nx  = code_ff;
      depth_nx = depth_ff;
      if (have_left_ff) begin
         if (lft_rdata != child_ff) begin
            code_nx = code_ff | (CODE_W'(1) << depth_ff);
         end
         depth_nx = depth_ff + DW'(1);
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      n_in         = n_ff;
      total_in     = total_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      scan_vld_in  = 1'b0;
      scan_idx_in  = j_ff;
      best_vld_in  = best_vld_ff;
      best_idx_in  = best_idx_ff;
      best_w_in    = best_w_ff;
      sec_vld_in   = sec_vld_ff;
      sec_idx_in   = sec_idx_ff;
      sec_w_in     = sec_w_ff;
      s_in         = s_ff;
      node_in      = node_ff;
      child_in     = child_ff;
      have_left_in = have_left_ff;
      code_in      = code_ff;
      depth_in     = depth_ff;

      wt_we     = 1'b0;
      wt_waddr  = NI'(count_ff);
      wt_wdata  = w_used;
      wt_raddr  = j_ff;
      par_we    = 1'b0;
      par_waddr = j_ff;
      par_wdata = '0;
      par_raddr = j_ff;
      lft_we    = 1'b0;
      lft_waddr = i_ff;
      lft_wdata = best_idx_ff;
      lft_raddr = up_idx;

      req_tready = 1'b0;
      rsp_tvalid = 1'b0;

      // shared two-minimum compare, fed one node per cycle by the scan
      if (scan_vld_ff && par_rdata == '0) begin
         if (!best_vld_ff || wt_rdata < best_w_ff) begin
            sec_vld_in  = best_vld_ff;
            sec_idx_in  = best_idx_ff;
            sec_w_in    = best_w_ff;
            best_vld_in = 1'b1;
            best_idx_in = scan_idx_ff;
            best_w_in   = wt_rdata;
         end else if (!sec_vld_ff || wt_rdata < sec_w_ff) begin
            sec_vld_in = 1'b1;
            sec_idx_in = scan_idx_ff;
            sec_w_in   = wt_rdata;
         end
      end

      case (state_ff)
         hcb_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (count_ff < CW'(MAX_SYMBOLS)) begin
                  wt_we    = 1'b1;
                  count_in = count_ff + CW'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_tlast) begin
                  n_in     = count_in;
                  total_in = NI'((32'(count_in) << 1) - 32'd1);
                  j_in     = '0;
                  state_in = hcb_pkg::S_CLEAR;
               end
            end
         end
         hcb_pkg::S_CLEAR: begin
            par_we = 1'b1;
            if (j_ff == total_ff - NI'(1)) begin
               if (n_ff == CW'(1)) begin
                  s_in     = '0;
                  state_in = hcb_pkg::S_WSTART;
               end else begin
                  i_in        = NI'(n_ff);
                  j_in        = '0;
                  best_vld_in = 1'b0;
                  sec_vld_in  = 1'b0;
                  state_in    = hcb_pkg::S_SCAN;
               end
            end else begin
               j_in = j_ff + NI'(1);
            end
         end
         hcb_pkg::S_SCAN: begin
            scan_vld_in = 1'b1;
            if (j_ff == i_ff - NI'(1)) begin
               state_in = hcb_pkg::S_DRAIN;
            end else begin
               j_in = j_ff + NI'(1);
            end
         end
         hcb_pkg::S_DRAIN: begin
            state_in = hcb_pkg::S_WR1;
         end
         hcb_pkg::S_WR1: begin
            par_we    = 1'b1;
            par_waddr = best_idx_ff;
            par_wdata = i_ff + NI'(1);
            lft_we    = 1'b1;
            wt_we     = 1'b1;
            wt_waddr  = i_ff;
            wt_wdata  = best_w_ff + sec_w_ff;
            state_in  = hcb_pkg::S_WR2;
         end
         hcb_pkg::S_WR2: begin
            par_we    = 1'b1;
            par_waddr = sec_idx_ff;
            par_wdata = i_ff + NI'(1);
            if (i_ff + NI'(1) == total_ff) begin
               s_in     = '0;
               state_in = hcb_pkg::S_WSTART;
            end else begin
               i_in        = i_ff + NI'(1);
               j_in        = '0;
               best_vld_in = 1'b0;
               sec_vld_in  = 1'b0;
               state_in    = hcb_pkg::S_SCAN;
            end
         end
         hcb_pkg::S_WSTART: begin
            par_raddr    = NI'(s_ff);
            node_in      = NI'(s_ff);
            have_left_in = 1'b0;
            code_in      = '0;
            depth_in     = '0;
            state_in     = hcb_pkg::S_WPAR;
         end
         hcb_pkg::S_WPAR: begin
            code_in  = code_nx;
            depth_in = depth_nx;
            if (par_rdata == '0) begin
               state_in = hcb_pkg::S_OUT;
            end else begin
               par_raddr    = up_idx;
               child_in     = node_ff;
               node_in      = up_idx;
               have_left_in = 1'b1;
            end
         end
         hcb_pkg::S_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (s_ff == n_ff - CW'(1)) begin
                  count_in   = '0;
                  dropped_in = 1'b0;
                  state_in   = hcb_pkg::S_IDLE;
               end else begin
                  s_in     = s_ff + CW'(1);
                  state_in = hcb_pkg::S_WSTART;
               end
            end
         end
         default: begin
            state_in = hcb_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= hcb_pkg::S_IDLE;
         count_ff    <= '0;
         dropped_ff  <= 1'b0;
         scan_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         dropped_ff  <= dropped_in;
         scan_vld_ff <= scan_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      total_ff     <= total_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      scan_idx_ff  <= scan_idx_in;
      best_vld_ff  <= best_vld_in;
      best_idx_ff  <= best_idx_in;
      best_w_ff    <= best_w_in;
      sec_vld_ff   <= sec_vld_in;
      sec_idx_ff   <= sec_idx_in;
      sec_w_ff     <= sec_w_in;
      s_ff         <= s_in;
      node_ff      <= node_in;
      child_ff     <= child_in;
      have_left_ff <= have_left_in;
      code_ff      <= code_in;
      depth_ff     <= depth_in;
   end

   assign sym_ext   = 32'(s_ff);
   assign depth_ext = 32'(depth_ff);

   assign rsp_tdata = {hcb_pkg::RSP_PAD_W'(0),
                       depth_ext[hcb_pkg::RSP_LENGTH_W-1:0],
                       code_ff,
                       sym_ext[hcb_pkg::RSP_SYMBOL_W-1:0]};
   assign rsp_tuser = dropped_ff;
   assign rsp_tlast = (s_ff == n_ff - CW'(1));

endmodule
